// ===== src/sbht_pkg.sv =====
`timescale 1ns / 1ps
// Package for the safe boot hold timer: phase codes, register indexes,
// register reset values and the structs shared by the core and the top level.
// No dependencies.
package sbht_pkg;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned IMAGE_W = 4;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [IMAGE_W-1:0] FACTORY_IMAGE_CODE = 4'd0;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_S1   = 3'd2,
    PH_S2   = 3'd3,
    PH_S3   = 3'd4
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_WAIT         = 3'd0,
    REG_STAGE_ONE_TIME     = 3'd1,
    REG_STAGE_ONE_PERIOD   = 3'd2,
    REG_STAGE_TWO_TIME     = 3'd3,
    REG_STAGE_TWO_PERIOD   = 3'd4,
    REG_STAGE_THREE_TIME   = 3'd5,
    REG_STAGE_THREE_PERIOD = 3'd6,
    REG_PREVIOUS_IMAGE     = 3'd7
  } reg_index_t;

  localparam logic [TIME_W-1:0] START_WAIT_RST         = 16'd100;
  localparam logic [TIME_W-1:0] STAGE_ONE_TIME_RST     = 16'd3000;
  localparam logic [TIME_W-1:0] STAGE_ONE_PERIOD_RST   = 16'd500;
  localparam logic [TIME_W-1:0] STAGE_TWO_TIME_RST     = 16'd3000;
  localparam logic [TIME_W-1:0] STAGE_TWO_PERIOD_RST   = 16'd250;
  localparam logic [TIME_W-1:0] STAGE_THREE_TIME_RST   = 16'd1500;
  localparam logic [TIME_W-1:0] STAGE_THREE_PERIOD_RST = 16'd100;
  localparam logic [IMAGE_W-1:0] PREVIOUS_IMAGE_RST    = 4'd0;

  typedef struct packed {
    logic [TIME_W-1:0]  start_wait;
    logic [TIME_W-1:0]  stage_one_time;
    logic [TIME_W-1:0]  stage_one_period;
    logic [TIME_W-1:0]  stage_two_time;
    logic [TIME_W-1:0]  stage_two_period;
    logic [TIME_W-1:0]  stage_three_time;
    logic [TIME_W-1:0]  stage_three_period;
    logic [IMAGE_W-1:0] previous_image;
  } cfg_t;

  typedef struct packed {
    logic               busy_res;
    logic               led_on;
    logic               done_res;
    logic               safe_boot;
    logic               image_override;
    logic [IMAGE_W-1:0] active_image;
  } result_t;

endpackage

// ===== src/sbht_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the safe boot hold timer: one for tick
// items, one for results. Depends on sbht_pkg.
interface sbht_item_if;
  logic valid;
  logic ready;
  logic start_req;
  logic pin_level;

  modport source (output valid, output start_req, output pin_level, input ready);
  modport sink   (input valid, input start_req, input pin_level, output ready);
endinterface

interface sbht_result_if;
  logic                           valid;
  logic                           ready;
  logic                           busy_res;
  logic                           led_on;
  logic                           done_res;
  logic                           safe_boot;
  logic                           image_override;
  logic [sbht_pkg::IMAGE_W-1:0]   active_image;

  modport source (output valid, output busy_res, output led_on, output done_res,
                  output safe_boot, output image_override, output active_image,
                  input ready);
  modport sink   (input valid, input busy_res, input led_on, input done_res,
                  input safe_boot, input image_override, input active_image,
                  output ready);
endinterface

// ===== src/sbht_core.sv =====
`timescale 1ns / 1ps
// Phase sequencer and blink timing of the safe boot hold timer. Holds the
// check state, advances it once per accepted tick. Depends on sbht_pkg.
module sbht_core #(
  parameter logic [sbht_pkg::IMAGE_W-1:0] FACTORY_IMAGE = sbht_pkg::FACTORY_IMAGE_CODE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              start_req,
  input  logic              pin_level,
  input  sbht_pkg::cfg_t    cfg,
  output sbht_pkg::result_t result
);

  sbht_pkg::phase_t                phase, phase_next;
  logic [sbht_pkg::TIME_W-1:0]     period_counter, period_counter_next;
  logic [sbht_pkg::TIME_W-1:0]     stage_elapsed, stage_elapsed_next;
  logic                            led_toggle, led_toggle_next;
  logic                            led_state, led_state_next;
  logic [sbht_pkg::IMAGE_W-1:0]    chosen_image, chosen_image_next;
  logic                            override_flag, override_flag_next;
  logic                            safe_flag, safe_flag_next;
  logic                            done;

  logic [sbht_pkg::TIME_W-1:0]     limit, period, period_eff;
  logic                            force_run, counting, blink, stage_end, wait_over;
  logic [sbht_pkg::TIME_W:0]       elapsed_sum;
  logic [sbht_pkg::TIME_W-1:0]     elapsed_sat;

  always_comb begin
    limit     = cfg.stage_one_time;
    period    = cfg.stage_one_period;
    force_run = 1'b0;
    case (phase)
      sbht_pkg::PH_S2: begin
        limit  = cfg.stage_two_time;
        period = cfg.stage_two_period;
      end
      sbht_pkg::PH_S3: begin
        limit     = cfg.stage_three_time;
        period    = cfg.stage_three_period;
        force_run = 1'b1;
      end
      default: begin
        limit  = cfg.stage_one_time;
        period = cfg.stage_one_period;
      end
    endcase
  end

  assign period_eff  = (period == '0) ? sbht_pkg::TIME_W'(1) : period;
  assign counting    = (period_counter != '0);
  assign blink       = !counting && (force_run || pin_level) && (stage_elapsed < limit);
  assign stage_end   = !counting && !blink;
  assign wait_over   = (period_counter <= sbht_pkg::TIME_W'(1));
  assign elapsed_sum = {1'b0, stage_elapsed} + {1'b0, period_eff};
  assign elapsed_sat = elapsed_sum[sbht_pkg::TIME_W] ? '1 : elapsed_sum[sbht_pkg::TIME_W-1:0];

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      sbht_pkg::PH_WAIT: begin
        if (wait_over) phase_next = pin_level ? sbht_pkg::PH_S1 : sbht_pkg::PH_IDLE;
      end
      sbht_pkg::PH_S1: begin
        if (stage_end) phase_next = pin_level ? sbht_pkg::PH_S2 : sbht_pkg::PH_IDLE;
      end
      sbht_pkg::PH_S2: begin
        if (stage_end) phase_next = pin_level ? sbht_pkg::PH_S3 : sbht_pkg::PH_IDLE;
      end
      sbht_pkg::PH_S3: begin
        if (stage_end) phase_next = sbht_pkg::PH_IDLE;
      end
      default: begin
        phase_next = (start_req && pin_level) ? sbht_pkg::PH_WAIT : sbht_pkg::PH_IDLE;
      end
    endcase
  end

  // counters, LED and outcome
  always_comb begin
    period_counter_next = period_counter;
    stage_elapsed_next  = stage_elapsed;
    led_toggle_next     = led_toggle;
    led_state_next      = led_state;
    chosen_image_next   = chosen_image;
    override_flag_next  = override_flag;
    safe_flag_next      = safe_flag;
    done                = 1'b0;
    case (phase)
      sbht_pkg::PH_WAIT: begin
        if (!wait_over) begin
          period_counter_next = period_counter - 1'b1;
        end else if (pin_level) begin
          period_counter_next = '0;
          stage_elapsed_next  = '0;
        end else begin
          done = 1'b1;
        end
      end
      sbht_pkg::PH_S1, sbht_pkg::PH_S2, sbht_pkg::PH_S3: begin
        if (counting) begin
          period_counter_next = period_counter - 1'b1;
        end else if (blink) begin
          led_state_next      = led_toggle;
          led_toggle_next     = !led_toggle;
          period_counter_next = period_eff - 1'b1;
          stage_elapsed_next  = elapsed_sat;
        end else if (pin_level && phase != sbht_pkg::PH_S3) begin
          chosen_image_next   = (phase == sbht_pkg::PH_S1) ? cfg.previous_image : FACTORY_IMAGE;
          override_flag_next  = 1'b1;
          period_counter_next = '0;
          stage_elapsed_next  = '0;
        end else begin
          led_state_next = 1'b0;
          safe_flag_next = 1'b1;
          done           = 1'b1;
        end
      end
      default: begin
        if (start_req) begin
          safe_flag_next     = 1'b0;
          override_flag_next = 1'b0;
          chosen_image_next  = '0;
          if (pin_level) period_counter_next = cfg.start_wait;
          else done = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sbht_pkg::PH_IDLE;
      period_counter <= '0;
      stage_elapsed  <= '0;
      led_toggle     <= 1'b1;
      led_state      <= 1'b0;
      chosen_image   <= '0;
      override_flag  <= 1'b0;
      safe_flag      <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      period_counter <= period_counter_next;
      stage_elapsed  <= stage_elapsed_next;
      led_toggle     <= led_toggle_next;
      led_state      <= led_state_next;
      chosen_image   <= chosen_image_next;
      override_flag  <= override_flag_next;
      safe_flag      <= safe_flag_next;
    end
  end

  assign result.busy_res       = (phase_next != sbht_pkg::PH_IDLE);
  assign result.led_on         = led_state_next;
  assign result.done_res       = done;
  assign result.safe_boot      = safe_flag_next;
  assign result.image_override = override_flag_next;
  assign result.active_image   = chosen_image_next;

endmodule

// ===== src/safe_boot_hold_timer_top.sv =====
`timescale 1ns / 1ps
// Top level of the safe boot hold timer: configuration registers, tick
// channel, result register. Depends on sbht_pkg, sbht_if and sbht_core.
// Each tick transaction (one millisecond of time) yields exactly one result
// transaction. The block takes a tick in every cycle while the result register
// is free: the state update is one pass of logic from the state registers to
// the result register, so a tick is accepted whenever the result register is
// empty or being emptied in the same cycle, and its result appears in the cycle
// after acceptance. The user must write registers through the write port only
// while no check is running; the block does not enforce this. After reset they
// hold the default timing (100 ms start wait, 3 s / 500 ms stage one, 3 s /
// 250 ms stage two, 1.5 s / 100 ms stage three, previous image 0).
module safe_boot_hold_timer_top #(
  parameter logic [sbht_pkg::IMAGE_W-1:0] FACTORY_IMAGE = sbht_pkg::FACTORY_IMAGE_CODE
) (
  input  logic                               clk,
  input  logic                               rst,
  sbht_item_if.sink                          item,
  sbht_result_if.source                      result,
  input  logic                               write_en,
  input  logic [sbht_pkg::CFG_INDEX_W-1:0]   write_index,
  input  logic [sbht_pkg::CFG_DATA_W-1:0]    write_data
);

  sbht_pkg::cfg_t    cfg;
  sbht_pkg::result_t core_result;
  sbht_pkg::result_t result_reg;
  logic              result_valid;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_wait         <= sbht_pkg::START_WAIT_RST;
      cfg.stage_one_time     <= sbht_pkg::STAGE_ONE_TIME_RST;
      cfg.stage_one_period   <= sbht_pkg::STAGE_ONE_PERIOD_RST;
      cfg.stage_two_time     <= sbht_pkg::STAGE_TWO_TIME_RST;
      cfg.stage_two_period   <= sbht_pkg::STAGE_TWO_PERIOD_RST;
      cfg.stage_three_time   <= sbht_pkg::STAGE_THREE_TIME_RST;
      cfg.stage_three_period <= sbht_pkg::STAGE_THREE_PERIOD_RST;
      cfg.previous_image     <= sbht_pkg::PREVIOUS_IMAGE_RST;
    end else if (write_en) begin
      case (sbht_pkg::reg_index_t'(write_index))
        sbht_pkg::REG_START_WAIT:         cfg.start_wait         <= write_data;
        sbht_pkg::REG_STAGE_ONE_TIME:     cfg.stage_one_time     <= write_data;
        sbht_pkg::REG_STAGE_ONE_PERIOD:   cfg.stage_one_period   <= write_data;
        sbht_pkg::REG_STAGE_TWO_TIME:     cfg.stage_two_time     <= write_data;
        sbht_pkg::REG_STAGE_TWO_PERIOD:   cfg.stage_two_period   <= write_data;
        sbht_pkg::REG_STAGE_THREE_TIME:   cfg.stage_three_time   <= write_data;
        sbht_pkg::REG_STAGE_THREE_PERIOD: cfg.stage_three_period <= write_data;
        sbht_pkg::REG_PREVIOUS_IMAGE:
          cfg.previous_image <= write_data[sbht_pkg::IMAGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.ready = !rst && (!result_valid || result.ready);
  assign accept     = item.valid && item.ready;

  sbht_core #(
    .FACTORY_IMAGE (FACTORY_IMAGE)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .start_req (item.start_req),
    .pin_level (item.pin_level),
    .cfg       (cfg),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) result_reg <= core_result;
  end

  assign result.valid          = result_valid;
  assign result.busy_res       = result_reg.busy_res;
  assign result.led_on         = result_reg.led_on;
  assign result.done_res       = result_reg.done_res;
  assign result.safe_boot      = result_reg.safe_boot;
  assign result.image_override = result_reg.image_override;
  assign result.active_image   = result_reg.active_image;

endmodule

// ===== src/sbht_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the safe boot hold timer, bound to the top level.
// Depends on sbht_pkg and safe_boot_hold_timer_top.
module sbht_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             busy_res,
  input logic                             done_res,
  input logic                             image_override,
  input logic [sbht_pkg::IMAGE_W-1:0]     active_image
);

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("tick channel stalled with empty result register");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted tick produced no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && busy_res))
    else $error("result is both done and busy");

  a_image_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !image_override) |-> (active_image == '0))
    else $error("image code set without override");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(busy_res) && $stable(done_res)
      && $stable(image_override) && $stable(active_image)))
    else $error("stalled result changed");

endmodule

bind safe_boot_hold_timer_top sbht_checker u_sbht_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item.valid),
  .in_ready       (item.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .busy_res       (result.busy_res),
  .done_res       (result.done_res),
  .image_override (result.image_override),
  .active_image   (result.active_image)
);
